// File: rtl/core/fcr_pkg.sv
package fcr_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned RadiusW = 8;
  localparam int unsigned ColourW = 16;
  localparam int unsigned DecW    = 12;
  localparam int unsigned OctW    = 3;

  // largest ring the block will draw, a larger start radius saturates
  localparam int unsigned MaxRadius = 255;

  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic        [RadiusW-1:0] radius_t;
  typedef logic        [ColourW-1:0] colour_t;
  typedef logic signed [DecW-1:0]    dec_t;
  typedef logic        [OctW-1:0]    oct_t;

  // mirror codes, in emit order
  localparam oct_t OctPxPy = 3'd0;
  localparam oct_t OctPyPx = 3'd1;
  localparam oct_t OctNxPy = 3'd2;
  localparam oct_t OctPyNx = 3'd3;
  localparam oct_t OctNxNy = 3'd4;
  localparam oct_t OctNyNx = 3'd5;
  localparam oct_t OctPxNy = 3'd6;
  localparam oct_t OctNyPx = 3'd7;

  localparam oct_t OctLast = OctNyPx;

endpackage

// File: rtl/core/filled_circle_rasterizer.sv
// filled circle rasterizer
//
// input channel (in_valid_i / in_stall_o): one beat per command. action_i = 1
// is a start: it latches centre, radius and colour and returns an empty
// result. action_i = 0 is an advance: it returns one pixel of the filled
// circle, or an empty result (pixel_valid_o = 0) when nothing is being drawn.
// a start during a drawing drops the old circle; a zero radius draws nothing.
// the circle is drawn as concentric Bresenham rings from the outer radius down
// to 1, eight mirrored points per step; last_pixel_o marks the final pixel.
//
// output channel (out_valid_o / out_stall_i): exactly one result beat per
// input beat, in order. a beat's result is registered and presented from the
// edge that accepts it on. throughput is one beat per cycle unless stalled,
// set by the single output register; the ring stepping (a few small adds and
// compares on the step registers) finishes in the same cycle as the command.
//
// while the receiver stalls, the held result stays put and in_stall_o rises
// only once the output register is full and not being taken.
// reset (rst_ni low) empties the output register and leaves the block idle.
module filled_circle_rasterizer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  fcr_pkg::coord_t  centre_x_i,
  input  fcr_pkg::coord_t  centre_y_i,
  input  fcr_pkg::radius_t radius_i,
  input  fcr_pkg::colour_t colour_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             pixel_valid_o,
  output fcr_pkg::coord_t  pixel_x_o,
  output fcr_pkg::coord_t  pixel_y_o,
  output fcr_pkg::colour_t pixel_colour_o,
  output logic             last_pixel_o
);
  import fcr_pkg::*;

  // drawing state
  logic    busy_q, busy_d;
  coord_t  ctr_col_q, ctr_col_d;
  coord_t  ctr_row_q, ctr_row_d;
  colour_t colour_q, colour_d;
  radius_t ring_q, ring_d;
  radius_t sx_q, sx_d;
  radius_t sy_q, sy_d;
  dec_t    dec_q, dec_d;
  oct_t    oct_q, oct_d;

  // output register
  logic    ovalid_q;
  logic    pvalid_q, pvalid_d;
  coord_t  px_q, px_d;
  coord_t  py_q, py_d;
  colour_t pcol_q, pcol_d;
  logic    plast_q, plast_d;

  logic in_acc;

  // output register frees when empty or drained this cycle
  assign in_stall_o = ovalid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // start radius, saturated
  radius_t start_r;
  assign start_r = (RadiusW'(MaxRadius) < radius_i) ? RadiusW'(MaxRadius) : radius_i;

  // mirrored offsets
  coord_t ox, oy, nx, ny, dx, dy;
  assign ox = coord_t'({{(CoordW-RadiusW){1'b0}}, sx_q});
  assign oy = coord_t'({{(CoordW-RadiusW){1'b0}}, sy_q});
  assign nx = -ox;
  assign ny = -oy;

  always_comb begin
    case (oct_q)
      OctPxPy: begin dx = ox; dy = oy; end
      OctPyPx: begin dx = oy; dy = ox; end
      OctNxPy: begin dx = nx; dy = oy; end
      OctPyNx: begin dx = oy; dy = nx; end
      OctNxNy: begin dx = nx; dy = ny; end
      OctNyNx: begin dx = ny; dy = nx; end
      OctPxNy: begin dx = ox; dy = ny; end
      default: begin dx = ny; dy = ox; end
    endcase
  end

  // Bresenham step, done after the eighth mirror
  logic signed [DecW:0] inc_lt, inc_ge;
  logic [RadiusW:0]     nsx, nsy;
  logic                 dec_neg;

  assign dec_neg = dec_q[DecW-1];
  assign inc_lt  = (DecW+1)'(signed'({1'b0, sx_q, 2'b00})) + (DecW+1)'(6);
  assign inc_ge  = (DecW+1)'(signed'({1'b0, sx_q, 2'b00}))
                 - (DecW+1)'(signed'({1'b0, sy_q, 2'b00})) + (DecW+1)'(10);
  assign nsx     = {1'b0, sx_q} + 1'b1;
  assign nsy     = dec_neg ? {1'b0, sy_q} : ({1'b0, sy_q} - 1'b1);

  // initial decision of a ring: 3 - 2r
  function automatic dec_t ring_dec(radius_t r);
    ring_dec = dec_t'(3) - dec_t'({r, 1'b0});
  endfunction

  always_comb begin
    busy_d    = busy_q;
    ctr_col_d = ctr_col_q;
    ctr_row_d = ctr_row_q;
    colour_d  = colour_q;
    ring_d    = ring_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    dec_d     = dec_q;
    oct_d     = oct_q;
    pvalid_d  = 1'b0;
    px_d      = '0;
    py_d      = '0;
    pcol_d    = '0;
    plast_d   = 1'b0;

    if (action_i) begin
      // start beat
      ctr_col_d = centre_x_i;
      ctr_row_d = centre_y_i;
      colour_d  = colour_i;
      ring_d    = start_r;
      oct_d     = '0;
      sx_d      = '0;
      if (start_r == '0) begin
        busy_d = 1'b0;
        sy_d   = '0;
        dec_d  = '0;
      end else begin
        busy_d = 1'b1;
        sy_d   = start_r;
        dec_d  = ring_dec(start_r);
      end
    end else if (busy_q) begin
      pvalid_d = 1'b1;
      px_d     = ctr_col_q + dx;
      py_d     = ctr_row_q + dy;
      pcol_d   = colour_q;
      oct_d    = oct_q + 1'b1;
      if (oct_q == OctLast) begin
        dec_d = dec_neg ? dec_q + dec_t'(inc_lt) : dec_q + dec_t'(inc_ge);
        sx_d  = nsx[RadiusW-1:0];
        sy_d  = nsy[RadiusW-1:0];
        if (nsx > nsy) begin
          // ring done, move inward
          ring_d = ring_q - 1'b1;
          if (ring_q == RadiusW'(1)) begin
            busy_d  = 1'b0;
            plast_d = 1'b1;
            sx_d    = '0;
            sy_d    = '0;
            dec_d   = '0;
          end else begin
            sx_d  = '0;
            sy_d  = ring_q - 1'b1;
            dec_d = ring_dec(ring_q - 1'b1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      ctr_col_q <= '0;
      ctr_row_q <= '0;
      colour_q  <= '0;
      ring_q    <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      dec_q     <= '0;
      oct_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q    <= busy_d;
        ctr_col_q <= ctr_col_d;
        ctr_row_q <= ctr_row_d;
        colour_q  <= colour_d;
        ring_q    <= ring_d;
        sx_q      <= sx_d;
        sy_q      <= sy_d;
        dec_q     <= dec_d;
        oct_q     <= oct_d;
        ovalid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q  <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pvalid_q <= pvalid_d;
      px_q     <= px_d;
      py_q     <= py_d;
      pcol_q   <= pcol_d;
      plast_q  <= plast_d;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign pixel_valid_o  = pvalid_q;
  assign pixel_x_o      = px_q;
  assign pixel_y_o      = py_q;
  assign pixel_colour_o = pcol_q;
  assign last_pixel_o   = plast_q;

endmodule
